FILE: hdl/particle_physics_update_assert.svh
// Assertion macros shared by the particle step block.
// No dependencies; included by files that carry concurrent checks.
`ifndef PARTICLE_PHYSICS_UPDATE_ASSERT_SVH
`define PARTICLE_PHYSICS_UPDATE_ASSERT_SVH

// same-cycle implication
`define PPU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PPU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/ppu_pkg.sv
// Types, constants and helper functions for the particle step block.
// No dependencies; used by every module of the block.
package ppu_pkg;

	localparam int SPHERE_SLOTS_DEF = 5;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SPHERES = 1'd1;
	localparam logic [15:0] TIME_STEP_RST      = 16'd655;
	localparam logic [2:0]  ACTIVE_SPHERES_RST = 3'd1;

	typedef logic signed [31:0] q16_t;

	localparam q16_t GRAVITY_Q = -32'sd642253;
	localparam q16_t TENTH_Q   = 32'sd6554;

	localparam int MUL_W      = 34;
	localparam int PROD_W     = 68;
	localparam int DIV_NUM_W  = 48;
	localparam int DIV_DEN_W  = 32;
	localparam int SQRT_IN_W  = 62;
	localparam int SQRT_OUT_W = 31;

	typedef struct packed {
		logic        kind;
		logic [2:0]  slot;
		q16_t        pos_x;
		q16_t        pos_y;
		q16_t        pos_z;
		q16_t        vel_x;
		q16_t        vel_y;
		q16_t        vel_z;
		logic [15:0] damping;
		logic        alive;
		logic [30:0] sphere_radius;
	} in_item_t;

	typedef struct packed {
		q16_t new_x;
		q16_t new_y;
		q16_t new_z;
		q16_t prev_x;
		q16_t prev_y;
		q16_t prev_z;
		q16_t new_vx;
		q16_t new_vy;
		q16_t new_vz;
		logic still_alive;
	} out_item_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// clamp to the signed 32-bit range
	function automatic q16_t sat32(input logic signed [PROD_W-1:0] v);
		q16_t r;
		if (v[PROD_W-1:31] == '0 || v[PROD_W-1:31] == '1)
			r = v[31:0];
		else if (v[PROD_W-1])
			r = 32'sh8000_0000;
		else
			r = 32'sh7fff_ffff;
		return r;
	endfunction

	// magnitude of a signed word, read as unsigned (min value maps to 2^31)
	function automatic logic [31:0] mag32(input q16_t v);
		logic [31:0] r;
		r = v[31] ? 32'(-v) : 32'(v);
		return r;
	endfunction

	// power-on sphere table
	function automatic q16_t sph_init_cx(input int i);
		q16_t r;
		case (i)
			0:       r = -32'sd32768;
			1:       r = -32'sd111411;
			2:       r = 32'sd39322;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic q16_t sph_init_cy(input int i);
		q16_t r;
		case (i)
			0:       r = 32'sd58982;
			1:       r = 32'sd91750;
			2:       r = 32'sd98304;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic q16_t sph_init_cz(input int i);
		q16_t r;
		case (i)
			2:       r = 32'sd6554;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [30:0] sph_init_r(input int i);
		logic [30:0] r;
		case (i)
			0:       r = 31'd13107;
			1:       r = 31'd22938;
			2:       r = 31'd28180;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/ppu_mul.sv
// Shared signed multiplier with a registered product.
// Depends on ppu_pkg for operand and product widths.
module ppu_mul import ppu_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(a) * PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

FILE: hdl/ppu_div.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on ppu_pkg for widths and the request/status structs.
module ppu_div import ppu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  div_req_t             req,
	output div_stat_t            stat,
	output logic [DIV_NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic                 take;

	assign rem_sh = {rem_q[DIV_DEN_W-1:0], quo_q[DIV_NUM_W-1]};
	assign take   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NUM_W);
				rem_q  <= '0;
				quo_q  <= req.num;
				den_q  <= req.den;
			end else if (busy_q) begin
				rem_q <= take ? (rem_sh - {1'b0, den_q}) : rem_sh;
				quo_q <= {quo_q[DIV_NUM_W-2:0], take};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

FILE: hdl/ppu_sqrt.sv
// Digit-by-digit floor square root, one result bit per cycle.
// Depends on ppu_pkg for operand widths.
module ppu_sqrt import ppu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SQRT_IN_W-1:0]  rad,
	output logic                  done,
	output logic [SQRT_OUT_W-1:0] root
);

	localparam int CNT_W = $clog2(SQRT_OUT_W + 1);
	localparam int REM_W = SQRT_OUT_W + 4;

	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [SQRT_IN_W-1:0]  rad_q;
	logic [REM_W-1:0]      rem_q;
	logic [SQRT_OUT_W-1:0] root_q;
	logic [REM_W-1:0]      rem_sh;
	logic [REM_W-1:0]      trial;
	logic                  take;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[SQRT_IN_W-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});
	assign take   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SQRT_OUT_W);
				rad_q  <= rad;
				rem_q  <= '0;
				root_q <= '0;
			end else if (busy_q) begin
				rem_q  <= take ? (rem_sh - trial) : rem_sh;
				root_q <= {root_q[SQRT_OUT_W-2:0], take};
				rad_q  <= {rad_q[SQRT_IN_W-3:0], 2'b00};
				cnt_q  <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: hdl/particle_physics_update.sv
// Top level of the particle step block: sequencer, sphere table, config.
// Depends on ppu_pkg, ppu_mul, ppu_div, ppu_sqrt and the assertion header.
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------
//  in       | sink      | in_valid / in_ready     | in_data   (in_item_t)
//  out      | source    | out_valid / out_ready   | out_data  (out_item_t)
//  cfg      | sink      | cfg_we (no wait)        | cfg_idx, cfg_wdata
//
// A sphere write updates the table at its handshake and leaves the sequencer idle.
// A dead particle goes straight to the output state. A live particle's time grows
// with each tested sphere and is set by the one shared multiplier; a penetrated
// sphere adds a square root and three divides, and a ground bounce one divide.
// in_ready is high only while the sequencer is idle; a finished result sits in
// the output register so the next transaction can be taken while it waits.
// Reset restores the three default spheres and the register defaults at once.
`include "particle_physics_update_assert.svh"

module particle_physics_update import ppu_pkg::*; #(
	parameter int SPHERE_SLOTS = SPHERE_SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int SW = (SPHERE_SLOTS > 1) ? $clog2(SPHERE_SLOTS) : 1;
	localparam int CW = $clog2(SPHERE_SLOTS + 1);

	typedef enum logic [4:0] {
		S_IDLE, S_GRAV, S_GRAV_W, S_MOVE, S_MOVE_W, S_SPH, S_SQ, S_SQ_W,
		S_RR, S_RR_W, S_SQRT, S_DIV_N, S_DIV_NW, S_NR, S_NR_W, S_GND,
		S_SDIV_W, S_VT, S_VT_W, S_XH, S_XH_W, S_XL, S_XL_W, S_VS, S_VS_W,
		S_VD, S_VD_W, S_LIFE, S_OUT
	} state_t;

	state_t state_q;

	// config registers
	logic [15:0] ts_q;
	logic [2:0]  act_q;

	// sphere table
	q16_t        sph_cx_q [SPHERE_SLOTS];
	q16_t        sph_cy_q [SPHERE_SLOTS];
	q16_t        sph_cz_q [SPHERE_SLOTS];
	logic [30:0] sph_r_q  [SPHERE_SLOTS];

	// working particle
	q16_t        p_q  [3];
	q16_t        v_q  [3];
	q16_t        pr_q [3];
	q16_t        d_q  [3];
	logic [15:0] damp_q;
	logic        live_q;
	logic [1:0]  ax_q;
	logic [CW-1:0] j_q;
	logic [63:0] acc_q;
	logic [SQRT_OUT_W-1:0] dist_q;
	q16_t        n_q;
	q16_t        s_q;
	logic        div_neg_q;
	logic signed [48:0] x_q;
	logic signed [48:0] mhi_q;
	logic signed [48:0] m_q;

	out_item_t   out_q;
	logic        out_valid_q;

	// shared units
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_sh;
	div_req_t                 div_req;
	div_stat_t                div_stat;
	logic [DIV_NUM_W-1:0]     div_quo;
	logic signed [PROD_W-1:0] div_q_s;
	logic                     sqrt_start;
	logic                     sqrt_done;
	logic [SQRT_OUT_W-1:0]    sqrt_root;

	// combinational helpers
	logic [SW-1:0]      jx;
	logic [7:0]         slot_ext;
	logic [CW-1:0]      nsph;
	q16_t               c_sel [3];
	logic signed [32:0] d_full [3];
	logic [2:0]         far;
	logic signed [32:0] t_w;
	logic               in_acc;

	assign in_acc   = in_valid && in_ready;
	assign jx       = j_q[SW-1:0];
	assign slot_ext = 8'(in_data.slot);
	assign nsph     = (int'(act_q) > SPHERE_SLOTS) ? CW'(SPHERE_SLOTS) : CW'(act_q);
	assign prod_sh  = prod >>> 16;
	assign t_w      = $signed({17'b0, ts_q}) - 33'(s_q);
	assign div_q_s  = div_neg_q ? -$signed(PROD_W'(div_quo)) : $signed(PROD_W'(div_quo));

	assign c_sel[0] = sph_cx_q[jx];
	assign c_sel[1] = sph_cy_q[jx];
	assign c_sel[2] = sph_cz_q[jx];

	// offsets to the selected centre; an offset of magnitude 2^31 or more is far
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d_full[k] = 33'(p_q[k]) - 33'(c_sel[k]);
			far[k]    = (d_full[k][32] != d_full[k][31]) ||
				(d_full[k][31:0] == 32'h8000_0000);
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_GRAV: begin
				mul_a = MUL_W'(GRAVITY_Q);
				mul_b = MUL_W'({1'b0, ts_q});
			end
			S_MOVE: begin
				mul_a = MUL_W'(v_q[ax_q]);
				mul_b = MUL_W'({1'b0, ts_q});
			end
			S_SQ: begin
				mul_a = MUL_W'(d_q[ax_q]);
				mul_b = MUL_W'(d_q[ax_q]);
			end
			S_RR: begin
				mul_a = MUL_W'({1'b0, sph_r_q[jx]});
				mul_b = MUL_W'({1'b0, sph_r_q[jx]});
			end
			S_NR: begin
				mul_a = MUL_W'(n_q);
				mul_b = MUL_W'({1'b0, sph_r_q[jx]});
			end
			S_VT: begin
				mul_a = MUL_W'(v_q[ax_q]);
				mul_b = MUL_W'(t_w);
			end
			S_XH: begin
				mul_a = MUL_W'(x_q >>> 16);
				mul_b = MUL_W'({1'b0, damp_q});
			end
			S_XL: begin
				mul_a = MUL_W'({1'b0, x_q[15:0]});
				mul_b = MUL_W'({1'b0, damp_q});
			end
			S_VS: begin
				mul_a = MUL_W'(v_q[ax_q]);
				mul_b = MUL_W'(s_q);
			end
			S_VD: begin
				mul_a = MUL_W'(v_q[ax_q]);
				mul_b = MUL_W'({1'b0, damp_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// divide requests: unit normal component, or bounce crossing time
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		case (state_q)
			S_DIV_N: begin
				div_req.start = 1'b1;
				div_req.num   = DIV_NUM_W'({mag32(d_q[ax_q]), 16'h0000});
				div_req.den   = DIV_DEN_W'(dist_q);
			end
			S_GND: begin
				div_req.start = (p_q[1] <= 0) && (v_q[1] != 0);
				div_req.num   = DIV_NUM_W'({mag32(pr_q[1]), 16'h0000});
				div_req.den   = mag32(v_q[1]);
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	assign sqrt_start = (state_q == S_RR_W) && (acc_q != '0) && (acc_q < prod[63:0]);

	ppu_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	ppu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	ppu_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.rad    (acc_q[SQRT_IN_W-1:0]),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	// config and sphere table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q  <= TIME_STEP_RST;
			act_q <= ACTIVE_SPHERES_RST;
			for (int i = 0; i < SPHERE_SLOTS; i++) begin
				sph_cx_q[i] <= sph_init_cx(i);
				sph_cy_q[i] <= sph_init_cy(i);
				sph_cz_q[i] <= sph_init_cz(i);
				sph_r_q[i]  <= sph_init_r(i);
			end
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_TIME_STEP:      ts_q  <= cfg_wdata;
					REG_ACTIVE_SPHERES: act_q <= cfg_wdata[2:0];
					default:            ts_q  <= ts_q;
				endcase
			end
			if (in_acc && in_data.kind && (int'(slot_ext) < SPHERE_SLOTS)) begin
				sph_cx_q[slot_ext[SW-1:0]] <= in_data.pos_x;
				sph_cy_q[slot_ext[SW-1:0]] <= in_data.pos_y;
				sph_cz_q[slot_ext[SW-1:0]] <= in_data.pos_z;
				sph_r_q[slot_ext[SW-1:0]]  <= in_data.sphere_radius;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			ax_q        <= '0;
			j_q         <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc && !in_data.kind) begin
						p_q[0]  <= in_data.pos_x;
						p_q[1]  <= in_data.pos_y;
						p_q[2]  <= in_data.pos_z;
						pr_q[0] <= in_data.pos_x;
						pr_q[1] <= in_data.pos_y;
						pr_q[2] <= in_data.pos_z;
						v_q[0]  <= in_data.vel_x;
						v_q[1]  <= in_data.vel_y;
						v_q[2]  <= in_data.vel_z;
						damp_q  <= in_data.damping;
						live_q  <= in_data.alive;
						state_q <= in_data.alive ? S_GRAV : S_OUT;
					end
				end
				S_GRAV:   state_q <= S_GRAV_W;
				S_GRAV_W: begin
					v_q[1]  <= sat32(PROD_W'(v_q[1]) + prod_sh);
					ax_q    <= '0;
					state_q <= S_MOVE;
				end
				S_MOVE:   state_q <= S_MOVE_W;
				S_MOVE_W: begin
					p_q[ax_q] <= sat32(PROD_W'(p_q[ax_q]) + prod_sh);
					if (ax_q == 2'd2) begin
						j_q     <= '0;
						state_q <= S_SPH;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_MOVE;
					end
				end
				S_SPH: begin
					if (j_q >= nsph) begin
						state_q <= S_GND;
					end else if (far != 3'b000) begin
						j_q <= j_q + CW'(1);
					end else begin
						for (int k = 0; k < 3; k++)
							d_q[k] <= d_full[k][31:0];
						acc_q   <= '0;
						ax_q    <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ:   state_q <= S_SQ_W;
				S_SQ_W: begin
					acc_q <= acc_q + prod[63:0];
					if (ax_q == 2'd2) begin
						state_q <= S_RR;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_SQ;
					end
				end
				S_RR:   state_q <= S_RR_W;
				S_RR_W: begin
					if (sqrt_start) begin
						state_q <= S_SQRT;
					end else begin
						j_q     <= j_q + CW'(1);
						state_q <= S_SPH;
					end
				end
				S_SQRT: begin
					if (sqrt_done) begin
						dist_q  <= sqrt_root;
						ax_q    <= '0;
						state_q <= S_DIV_N;
					end
				end
				S_DIV_N: begin
					div_neg_q <= d_q[ax_q][31];
					state_q   <= S_DIV_NW;
				end
				S_DIV_NW: begin
					if (div_stat.done) begin
						n_q     <= sat32(div_q_s);
						state_q <= S_NR;
					end
				end
				S_NR:   state_q <= S_NR_W;
				S_NR_W: begin
					p_q[ax_q]  <= sat32(PROD_W'(c_sel[ax_q]) + prod_sh);
					pr_q[ax_q] <= sat32(PROD_W'(c_sel[ax_q]) + prod_sh);
					v_q[ax_q]  <= n_q;
					if (ax_q == 2'd2) begin
						j_q     <= j_q + CW'(1);
						state_q <= S_SPH;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_DIV_N;
					end
				end
				S_GND: begin
					ax_q <= '0;
					if (p_q[1] > 0) begin
						state_q <= S_LIFE;
					end else if (v_q[1] != 0) begin
						// s = -prev_y / vy, truncated toward zero
						div_neg_q <= (pr_q[1] > 0) ^ v_q[1][31];
						state_q   <= S_SDIV_W;
					end else begin
						s_q     <= '0;
						state_q <= S_VT;
					end
				end
				S_SDIV_W: begin
					if (div_stat.done) begin
						s_q     <= sat32(div_q_s);
						state_q <= S_VT;
					end
				end
				S_VT:   state_q <= S_VT_W;
				S_VT_W: begin
					x_q     <= prod_sh[48:0];
					state_q <= S_XH;
				end
				// floor(x * damp / 2^16) split into high and low halves of x
				S_XH:   state_q <= S_XH_W;
				S_XH_W: begin
					mhi_q   <= prod[48:0];
					state_q <= S_XL;
				end
				S_XL:   state_q <= S_XL_W;
				S_XL_W: begin
					m_q <= mhi_q + prod_sh[48:0];
					if (ax_q == 2'd1) begin
						p_q[1]  <= sat32(-PROD_W'(mhi_q + $signed(prod_sh[48:0])));
						ax_q    <= 2'd2;
						state_q <= S_VT;
					end else begin
						state_q <= S_VS;
					end
				end
				S_VS:   state_q <= S_VS_W;
				S_VS_W: begin
					p_q[ax_q] <= sat32(PROD_W'(pr_q[ax_q]) + prod_sh + PROD_W'(m_q));
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= S_VD;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_VT;
					end
				end
				S_VD:   state_q <= S_VD_W;
				S_VD_W: begin
					v_q[ax_q] <= (ax_q == 2'd1) ? sat32(-prod_sh) : sat32(prod_sh);
					if (ax_q == 2'd2) begin
						state_q <= S_LIFE;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_VD;
					end
				end
				S_LIFE: begin
					if (p_q[1] < TENTH_Q && v_q[1] < TENTH_Q && v_q[1] > -TENTH_Q)
						live_q <= 1'b0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_q.new_x       <= p_q[0];
						out_q.new_y       <= p_q[1];
						out_q.new_z       <= p_q[2];
						out_q.prev_x      <= pr_q[0];
						out_q.prev_y      <= pr_q[1];
						out_q.prev_z      <= pr_q[2];
						out_q.new_vx      <= v_q[0];
						out_q.new_vy      <= v_q[1];
						out_q.new_vz      <= v_q[2];
						out_q.still_alive <= live_q;
						out_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`PPU_ASSERT_IMP(a_div_start_idle, clk, arst_n, div_req.start, !div_stat.busy, "divide started while busy")
	`PPU_ASSERT_IMP(a_sqrt_nonzero, clk, arst_n, sqrt_done, sqrt_root != '0, "zero root of nonzero square")
	`PPU_ASSERT_NXT(a_particle_busy, clk, arst_n, in_acc && !in_data.kind, !in_ready, "particle not taken up")
	`PPU_ASSERT_IMP(a_sphere_range, clk, arst_n, state_q != S_IDLE, j_q <= CW'(SPHERE_SLOTS), "sphere index past table")

endmodule

FILE: tb/sv/particle_physics_update_chk.sv
// Checker for the particle step block: tracks config and sphere table, predicts
// each particle result and compares it with the output channel. Needs ppu_pkg.
`timescale 1ns / 1ps

module particle_physics_update_chk import ppu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  in_item_t              in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    fail_count,
	output int                    pending
);

	localparam int NSLOT = SPHERE_SLOTS_DEF;

	q16_t        ctr_x [NSLOT];
	q16_t        ctr_y [NSLOT];
	q16_t        ctr_z [NSLOT];
	logic [30:0] rad   [NSLOT];
	logic [15:0] dt_q;
	logic [2:0]  n_active;
	out_item_t   motion_q [$];

	initial fail_count = 0;
	initial pending = 0;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// floor of x / 2^16
	function automatic longint fl16(input longint x);
		return x >>> 16;
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned x);
		longint unsigned res, bitv;
		res  = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x   = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic out_item_t advance_particle(input in_item_t it);
		longint p[3], v[3], pr[3], c[3], d[3];
		longint dt, damp, r, s, t, m, n;
		longint unsigned d2, root_d;
		int nsph;
		bit live, far_off;
		out_item_t o;
		dt   = longint'(dt_q);
		damp = longint'(it.damping);
		live = it.alive;
		p[0] = it.pos_x; p[1] = it.pos_y; p[2] = it.pos_z;
		v[0] = it.vel_x; v[1] = it.vel_y; v[2] = it.vel_z;
		for (int i = 0; i < 3; i++) pr[i] = p[i];
		if (live) begin
			v[1] = clamp32(v[1] + fl16(longint'(GRAVITY_Q) * dt));
			for (int i = 0; i < 3; i++) begin
				pr[i] = p[i];
				p[i]  = clamp32(p[i] + fl16(v[i] * dt));
			end
			nsph = (n_active > NSLOT) ? NSLOT : int'(n_active);
			for (int j = 0; j < nsph; j++) begin
				c[0] = ctr_x[j]; c[1] = ctr_y[j]; c[2] = ctr_z[j];
				r = longint'(rad[j]);
				far_off = 0;
				for (int i = 0; i < 3; i++) begin
					d[i] = p[i] - c[i];
					if (d[i] >= 64'sd2147483648 || d[i] <= -64'sd2147483648) far_off = 1;
				end
				if (far_off) continue;
				d2 = longint'(d[0] * d[0]) + longint'(d[1] * d[1]) + longint'(d[2] * d[2]);
				if (d2 == 0 || d2 >= longint'(r * r)) continue;
				root_d = floor_sqrt(d2);
				if (root_d == 0) continue;
				for (int i = 0; i < 3; i++) begin
					n     = clamp32((d[i] * 65536) / longint'(root_d));
					p[i]  = clamp32(c[i] + fl16(n * r));
					pr[i] = p[i];
					v[i]  = n;
				end
			end
			// ground bounce
			if (p[1] <= 0) begin
				s = 0;
				if (v[1] != 0) s = clamp32((-pr[1] * 65536) / v[1]);
				t = dt - s;
				for (int i = 0; i < 3; i++) begin
					m = fl16(fl16(v[i] * t) * damp);
					if (i == 1) p[i] = clamp32(-m);
					else        p[i] = clamp32(pr[i] + fl16(v[i] * s) + m);
				end
				v[0] = clamp32(fl16(v[0] * damp));
				v[1] = clamp32(-fl16(v[1] * damp));
				v[2] = clamp32(fl16(v[2] * damp));
			end
			if (p[1] < longint'(TENTH_Q) && v[1] < longint'(TENTH_Q) &&
			    v[1] > -longint'(TENTH_Q))
				live = 0;
		end
		o.new_x  = p[0][31:0];  o.new_y  = p[1][31:0];  o.new_z  = p[2][31:0];
		o.prev_x = pr[0][31:0]; o.prev_y = pr[1][31:0]; o.prev_z = pr[2][31:0];
		o.new_vx = v[0][31:0];  o.new_vy = v[1][31:0];  o.new_vz = v[2][31:0];
		o.still_alive = live;
		return o;
	endfunction

	task automatic cmp_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t e;
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) begin
				ctr_x[i] = sph_init_cx(i);
				ctr_y[i] = sph_init_cy(i);
				ctr_z[i] = sph_init_cz(i);
				rad[i]   = sph_init_r(i);
			end
			dt_q     = TIME_STEP_RST;
			n_active = ACTIVE_SPHERES_RST;
			motion_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_TIME_STEP:      dt_q = cfg_wdata;
					REG_ACTIVE_SPHERES: n_active = cfg_wdata[2:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (in_data.kind) begin
					if (in_data.slot < NSLOT) begin
						ctr_x[in_data.slot] = in_data.pos_x;
						ctr_y[in_data.slot] = in_data.pos_y;
						ctr_z[in_data.slot] = in_data.pos_z;
						rad[in_data.slot]   = in_data.sphere_radius;
					end
				end else begin
					motion_q.push_back(advance_particle(in_data));
				end
			end
			if (out_valid && out_ready) begin
				if (motion_q.size() == 0) begin
					$error("result transaction with no particle outstanding");
					fail_count++;
				end else begin
					e = motion_q.pop_front();
					cmp_field("new_x", e.new_x, out_data.new_x);
					cmp_field("new_y", e.new_y, out_data.new_y);
					cmp_field("new_z", e.new_z, out_data.new_z);
					cmp_field("prev_x", e.prev_x, out_data.prev_x);
					cmp_field("prev_y", e.prev_y, out_data.prev_y);
					cmp_field("prev_z", e.prev_z, out_data.prev_z);
					cmp_field("new_vx", e.new_vx, out_data.new_vx);
					cmp_field("new_vy", e.new_vy, out_data.new_vy);
					cmp_field("new_vz", e.new_vz, out_data.new_vz);
					cmp_field("still_alive", 32'(e.still_alive), 32'(out_data.still_alive));
				end
			end
		end
		pending = motion_q.size();
	end

endmodule

FILE: tb/sv/particle_physics_update_tb.sv
// Top of the particle step testbench: clock, reset, stimulus and verdict.
// Depends on ppu_pkg, particle_physics_update and particle_physics_update_chk.
`timescale 1ns / 1ps

module particle_physics_update_tb;
	import ppu_pkg::*;

	localparam int CYCLE_LIMIT = 5000000;
	localparam int SETTLE      = 1500;
	localparam int PHASE_ITEMS = 175;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  in_valid = 0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 0;
	out_item_t             out_data;
	logic                  cfg_we = 0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	int                    fail_count;
	int                    pending;

	int send_idle = 0;   // percent of transactions preceded by a gap
	int recv_idle = 0;   // percent of cycles with out_ready low
	int cyc = 0;

	// stimulus-side copy of the sphere table, only used to aim particles
	q16_t        aim_x [SPHERE_SLOTS_DEF];
	q16_t        aim_y [SPHERE_SLOTS_DEF];
	q16_t        aim_z [SPHERE_SLOTS_DEF];
	logic [30:0] aim_r [SPHERE_SLOTS_DEF];

	always #6 clk = ~clk;

	particle_physics_update u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	particle_physics_update_chk u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	// receiver back-pressure
	always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle);

	// watchdog
	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$display("[particle_physics_update] ERROR");
			$finish;
		end
	end

	function automatic q16_t spread(input int span);
		return q16_t'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic in_item_t particle(input q16_t px, py, pz, vx, vy, vz,
			input logic [15:0] damp, input logic live);
		in_item_t it;
		it = '0;
		it.kind = 1'b0;
		it.slot = 3'($urandom);
		it.pos_x = px; it.pos_y = py; it.pos_z = pz;
		it.vel_x = vx; it.vel_y = vy; it.vel_z = vz;
		it.damping = damp;
		it.alive = live;
		it.sphere_radius = 31'($urandom);
		return it;
	endfunction

	function automatic in_item_t sphere(input logic [2:0] slot, input q16_t cx, cy, cz,
			input logic [30:0] r);
		in_item_t it;
		it = particle(cx, cy, cz, $urandom, $urandom, $urandom, 16'($urandom), 1'($urandom));
		it.kind = 1'b1;
		it.slot = slot;
		it.sphere_radius = r;
		return it;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transaction,
	// with in_valid still high so back-to-back items need no second assignment.
	task automatic send(input in_item_t it);
		if (it.kind && it.slot < SPHERE_SLOTS_DEF) begin
			aim_x[it.slot] = it.pos_x;
			aim_y[it.slot] = it.pos_y;
			aim_z[it.slot] = it.pos_z;
			aim_r[it.slot] = it.sphere_radius;
		end
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// idle the input, drain every expected result, then let a trailing write settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	function automatic in_item_t random_item();
		int pick, j, rs;
		q16_t ox, oy, oz;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			// sphere table write, some to slots that do not exist
			if ($urandom_range(0, 9) == 0)
				return sphere(3'($urandom), $urandom, $urandom, $urandom, 31'($urandom));
			return sphere(3'($urandom_range(0, 7)), spread(1 << 18), spread(1 << 18),
				spread(1 << 17), 31'($urandom_range(1000, 1 << 17)));
		end
		if (pick < 15)
			return particle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				16'($urandom), 1'b0);
		if (pick < 25)
			return particle($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				16'($urandom), 1'b1);
		if (pick < 60) begin
			// aimed into or near a sphere
			j  = $urandom_range(0, SPHERE_SLOTS_DEF - 1);
			rs = (aim_r[j] > (1 << 18)) ? (1 << 18) : int'(aim_r[j]) + 1;
			ox = aim_x[j] + spread(rs);
			oy = aim_y[j] + spread(rs);
			oz = aim_z[j] + spread(rs);
			return particle(ox, oy, oz, spread(1 << 17), spread(1 << 17), spread(1 << 17),
				16'($urandom), 1'b1);
		end
		if (pick < 85)
			// at or near the ground, slow enough to bounce or come to rest
			return particle(spread(1 << 18), spread(1 << 16), spread(1 << 18),
				spread(1 << 16), spread(1 << 16), spread(1 << 16), 16'($urandom), 1'b1);
		return particle(spread(1 << 24), spread(1 << 24), spread(1 << 24),
			spread(1 << 22), spread(1 << 22), spread(1 << 22), 16'($urandom), 1'b1);
	endfunction

	initial begin
		logic [15:0] ts_tab  [8];
		logic [15:0] act_tab [8];
		ts_tab  = '{16'd0, 16'd65535, 16'd655, 16'd1, 16'd32768, 16'd3000, 16'd10, 16'd20000};
		act_tab = '{16'd5, 16'd0, 16'd7, 16'd3, 16'd1, 16'd2, 16'd4, 16'd6};
		for (int i = 0; i < SPHERE_SLOTS_DEF; i++) begin
			aim_x[i] = sph_init_cx(i);
			aim_y[i] = sph_init_cy(i);
			aim_z[i] = sph_init_cz(i);
			aim_r[i] = sph_init_r(i);
		end
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, reset config: dt 655, one sphere
		send(particle(32'sd1000, 32'sd70000, 32'sd5, 32'sd10, 32'sd20, 32'sd30, 16'hffff, 1'b0));
		send(particle(-32'sd32768, 32'sd58982, 32'sd100, 32'sd0, 32'sd6420, 32'sd0,
			16'h8000, 1'b1));                                // inside default sphere
		send(particle(-32'sd32768, 32'sd58982, 32'sd0, 32'sd0, 32'sd6420, 32'sd0,
			16'h8000, 1'b1));                                // exactly at the centre
		send(particle(32'sd100, 32'sd0, 32'sd100, 32'sd500, 32'sd6420, 32'sd500,
			16'hc000, 1'b1));                                // ground with zero vy
		send(particle(32'sd100, 32'sd2000, 32'sd100, 32'sd500, -32'sd90000, 32'sd500,
			16'h0000, 1'b1));                                // bounce, no damping kept
		send(particle(32'sd0, 32'sd3000, 32'sd0, 32'sd0, 32'sd6000, 32'sd0,
			16'hffff, 1'b1));                                // near still, dies
		send(particle(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff, 32'sh7fffffff, 16'hffff, 1'b1));
		send(particle(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, 32'sh80000000, 16'hffff, 1'b1));
		send(sphere(3'd7, 32'sd0, 32'sd0, 32'sd0, 31'h7fffffff));   // slot out of range
		send(sphere(3'd5, 32'sd0, 32'sd0, 32'sd0, 31'h7fffffff));
		send(sphere(3'd0, 32'sd0, 32'sd0, 32'sd0, 31'h7fffffff));   // huge sphere
		send(particle(32'sd1000, 32'sd2000, -32'sd3000, 32'sd0, 32'sd0, 32'sd0,
			16'h1234, 1'b1));
		send(particle(32'sh7fff0000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
			16'h1234, 1'b1));                                // far from the centre
		send(sphere(3'd0, -32'sd32768, 32'sd58982, 32'sd0, 31'd13107));
		send(sphere(3'd3, 32'sd0, 32'sd200000, 32'sd0, 31'd60000));
		send(sphere(3'd4, 32'sd0, 32'sd400000, 32'sd0, 31'd0));
		drain();
		write_reg(REG_ACTIVE_SPHERES, 16'd5);
		write_reg(REG_TIME_STEP, 16'd65535);
		send(particle(32'sd100, 32'sd200000, 32'sd50, 32'sd0, 32'sd0, 32'sd0,
			16'h4000, 1'b1));                                // sphere in slot 3
		send(particle(32'sd0, -32'sd100, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
			16'h4000, 1'b1));
		drain();
		write_reg(REG_TIME_STEP, 16'd0);
		send(particle(32'sd10, 32'sd0, 32'sd10, 32'sd0, 32'sd0, 32'sd0, 16'hffff, 1'b1));
		send(particle(32'sd10, 32'sd200000, 32'sd10, 32'sd1, -32'sd1, 32'sd1,
			16'hffff, 1'b1));

		// random part: three idling regimes over eight register settings
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			write_reg(REG_TIME_STEP, ts_tab[ph]);
			write_reg(REG_ACTIVE_SPHERES, act_tab[ph]);
			if (ph < 3) begin
				send_idle = 11; recv_idle = 79;
			end else if (ph < 6) begin
				send_idle = 79; recv_idle = 11;
			end else begin
				send_idle = 0; recv_idle = 0;
			end
			for (int k = 0; k < PHASE_ITEMS; k++) send(random_item());
		end

		drain();
		if (fail_count == 0)
			$display("[particle_physics_update] OK");
		else
			$display("[particle_physics_update] ERROR");
		$finish;
	end

endmodule
